>>> sv/btb_pkg.sv
// ----------------------------------------------------------------------------
// BTB predictor package
// Shared constants and register indexes for the branch target buffer.
// ----------------------------------------------------------------------------
package btb_pkg;
    localparam int MAX_ENTRIES = 32;
    localparam int MAX_HISTORY = 8;
    localparam int SLOT_W      = 5;
    localparam int SHARED_SIZE = 256;
    localparam int LOCAL_AW    = SLOT_W + MAX_HISTORY;
    localparam int ENTRY_W     = 30 + 32;   // tag, target
    localparam int PADDR_W     = 5;

    localparam logic [2:0] REG_INDEX   = 3'd0;
    localparam logic [2:0] REG_HISTORY = 3'd1;
    localparam logic [2:0] REG_TAG     = 3'd2;
    localparam logic [2:0] REG_DEFAULT = 3'd3;
    localparam logic [2:0] REG_SHHIST  = 3'd4;
    localparam logic [2:0] REG_SHTAB   = 3'd5;
    localparam logic [2:0] REG_XOR     = 3'd6;

    localparam logic [1:0] XOR_LOW  = 2'd1;
    localparam logic [1:0] XOR_HIGH = 2'd2;

    localparam logic OP_PREDICT = 1'b0;
    localparam logic OP_UPDATE  = 1'b1;
endpackage

>>> sv/btb_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module btb_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> sv/btb_two_level_branch_predictor.sv
// ----------------------------------------------------------------------------
// Two-level branch predictor with BTB
// Direct-mapped target buffer with local or global history, local or shared
// (optionally gshare) 2-bit counter tables.
// ----------------------------------------------------------------------------
// Predict and update take the same path from input transfer to the earliest
// result transfer: entry read, counter read, result register. Allocating or
// replacing an entry adds a sweep that rewrites all of that entry's local
// counters with default_counter. One item at a time: the next input transfer
// is taken only after the result transfer, once the sequencer is idle again.
// After reset a pass loads the whole shared table with the reset default.
module btb_two_level_branch_predictor (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [btb_pkg::PADDR_W-1:0]   paddr,
    input  logic [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic                          s_operation,
    input  logic [31:0]                   s_pc,
    input  logic [31:0]                   s_actual_target,
    input  logic                          s_taken,
    input  logic [31:0]                   s_predicted_target,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic                          m_predict_taken,
    output logic [31:0]                   m_next_pc,
    output logic [31:0]                   m_branch_count,
    output logic [31:0]                   m_flush_count
);
    import btb_pkg::*;

    localparam logic [2:0] ST_INIT  = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_ENTRY = 3'd2;  // entry read data arrives
    localparam logic [2:0] ST_SWEEP = 3'd3;  // rewrite local counters with default_counter
    localparam logic [2:0] ST_CTR   = 3'd4;  // counter read data arrives
    localparam logic [2:0] ST_OUT   = 3'd5;

    // default_counter value at reset; the shared table starts from it
    localparam logic [1:0] CTR_RESET = 2'd1;

    // ---------------- configuration registers ----------------
    logic [2:0] index_bits_reg;
    logic [3:0] history_bits_reg;
    logic [4:0] tag_bits_reg;
    logic [1:0] default_counter_reg;
    logic       shared_history_reg;
    logic       shared_table_reg;
    logic [1:0] xor_mode_reg;

    logic       cfg_wr;
    logic [2:0] cfg_idx;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = paddr[4:2];
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            index_bits_reg      <= 3'd0;
            history_bits_reg    <= 4'd1;
            tag_bits_reg        <= 5'd0;
            default_counter_reg <= CTR_RESET;
            shared_history_reg  <= 1'b0;
            shared_table_reg    <= 1'b0;
            xor_mode_reg        <= 2'd0;
        end else if (cfg_wr) begin
            unique case (cfg_idx)
                REG_INDEX:   index_bits_reg      <= pwdata[2:0];
                REG_HISTORY: history_bits_reg    <= pwdata[3:0];
                REG_TAG:     tag_bits_reg        <= pwdata[4:0];
                REG_DEFAULT: default_counter_reg <= pwdata[1:0];
                REG_SHHIST:  shared_history_reg  <= pwdata[0];
                REG_SHTAB:   shared_table_reg    <= pwdata[0];
                REG_XOR:     xor_mode_reg        <= pwdata[1:0];
                default:     ;
            endcase
        end
    end

    always_comb begin
        prdata = 32'd0;
        unique case (cfg_idx)
            REG_INDEX:   prdata = {29'd0, index_bits_reg};
            REG_HISTORY: prdata = {28'd0, history_bits_reg};
            REG_TAG:     prdata = {27'd0, tag_bits_reg};
            REG_DEFAULT: prdata = {30'd0, default_counter_reg};
            REG_SHHIST:  prdata = {31'd0, shared_history_reg};
            REG_SHTAB:   prdata = {31'd0, shared_table_reg};
            REG_XOR:     prdata = {30'd0, xor_mode_reg};
            default:     prdata = 32'd0;
        endcase
    end

    // ---------------- effective settings ----------------
    logic [2:0] eff_ib;
    logic [3:0] eff_hb;
    logic [4:0] eff_tb;
    logic [7:0] hmask;
    assign eff_ib = (index_bits_reg > 3'd5) ? 3'd5 : index_bits_reg;
    assign eff_hb = (history_bits_reg == 4'd0) ? 4'd1 :
                    (history_bits_reg > 4'd8) ? 4'd8 : history_bits_reg;
    assign eff_tb = (tag_bits_reg > 5'd30 - {2'd0, eff_ib}) ?
                    5'd30 - {2'd0, eff_ib} : tag_bits_reg;
    assign hmask  = 8'(({1'b0, 8'hff} << eff_hb) ^ 9'h1ff);

    // ---------------- captured item ----------------
    logic [2:0]  state_reg, state_next;
    logic        op_reg;
    logic [31:0] pc_reg, tgt_reg, pred_reg;
    logic        tk_reg;
    logic [SLOT_W-1:0] slot_reg;
    logic [29:0] tag_reg;
    logic        hit_reg;     // entry valid with matching tag
    logic [7:0]  hist_reg;    // history used for this item
    logic [31:0] etarget_reg;
    logic [7:0]  cidx_reg;
    logic [7:0]  sweep_reg;

    logic [MAX_ENTRIES-1:0] valid_reg;
    logic [7:0] ghist_reg;
    logic [7:0] lhist_reg [MAX_ENTRIES];
    logic [31:0] branch_reg, flush_reg;
    logic        m_valid_reg, ptaken_reg;
    logic [31:0] npc_reg;

    logic s_fire;
    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign s_fire  = s_valid && s_ready;

    logic [SLOT_W-1:0] in_slot;
    logic [29:0]       in_tag;
    assign in_slot = SLOT_W'((s_pc >> 2) & ((32'd1 << eff_ib) - 32'd1));
    assign in_tag  = 30'((s_pc >> (6'd2 + {3'd0, eff_ib})) &
                         ((32'd1 << eff_tb) - 32'd1));

    // ---------------- entry memory (tag, target) ----------------
    logic              ent_we;
    logic [ENTRY_W-1:0] ent_rdata;
    btb_ram #(.WIDTH(ENTRY_W), .DEPTH(MAX_ENTRIES)) u_entry_ram (
        .aclk  (aclk),
        .we    (ent_we),
        .waddr (slot_reg),
        .wdata ({tag_reg, tgt_reg}),
        .raddr (in_slot),
        .rdata (ent_rdata)
    );
    assign ent_we = (state_reg == ST_CTR) && op_reg == OP_UPDATE;

    // ---------------- counter memories ----------------
    logic              loc_we, sh_we;
    logic [LOCAL_AW-1:0] loc_waddr, loc_raddr;
    logic [7:0]        sh_waddr;
    logic [1:0]        loc_wdata, sh_wdata, loc_rdata, sh_rdata;
    logic              hit_c, alloc_c;
    logic [7:0]        hist_c, cidx_next_c;
    btb_ram #(.WIDTH(2), .DEPTH(MAX_ENTRIES*SHARED_SIZE)) u_local_ram (
        .aclk(aclk), .we(loc_we), .waddr(loc_waddr), .wdata(loc_wdata),
        .raddr(loc_raddr), .rdata(loc_rdata)
    );
    btb_ram #(.WIDTH(2), .DEPTH(SHARED_SIZE)) u_shared_ram (
        .aclk(aclk), .we(sh_we), .waddr(sh_waddr), .wdata(sh_wdata),
        .raddr(cidx_next_c), .rdata(sh_rdata)
    );

    // counter index, formed in ST_ENTRY (or in ST_SWEEP)
    assign hit_c  = valid_reg[slot_reg] && ent_rdata[61:32] == tag_reg;
    assign alloc_c = op_reg == OP_UPDATE && !hit_c;
    always_comb begin
        if (shared_history_reg) hist_c = ghist_reg;
        else if (state_reg == ST_ENTRY && alloc_c) hist_c = 8'd0;
        else if (state_reg == ST_SWEEP) hist_c = 8'd0;
        else hist_c = lhist_reg[slot_reg];
        cidx_next_c = hist_c & hmask;
        if (shared_table_reg) begin
            if (xor_mode_reg == XOR_LOW)
                cidx_next_c = cidx_next_c ^ (pc_reg[9:2] & hmask);
            else if (xor_mode_reg == XOR_HIGH)
                cidx_next_c = cidx_next_c ^ (pc_reg[23:16] & hmask);
        end
    end
    assign loc_raddr = {slot_reg, cidx_next_c};

    // step the counter that was read; a freshly swept local table holds
    // default_counter everywhere, so take it directly
    logic [1:0] ctr_c, ctr_new_c;
    assign ctr_c = shared_table_reg ? sh_rdata :
                   (op_reg == OP_UPDATE && !hit_reg) ? default_counter_reg : loc_rdata;
    always_comb begin
        ctr_new_c = ctr_c;
        if (tk_reg && ctr_c != 2'd3) ctr_new_c = ctr_c + 2'd1;
        else if (!tk_reg && ctr_c != 2'd0) ctr_new_c = ctr_c - 2'd1;
    end

    logic upd_ctr;
    assign upd_ctr = state_reg == ST_CTR && op_reg == OP_UPDATE;

    // sweep writes default into the local table; init fills the shared one
    assign loc_we    = state_reg == ST_SWEEP || (upd_ctr && !shared_table_reg);
    assign loc_waddr = state_reg == ST_SWEEP ? {slot_reg, sweep_reg}
                                             : {slot_reg, cidx_reg};
    assign loc_wdata = state_reg == ST_SWEEP ? default_counter_reg : ctr_new_c;
    assign sh_we     = state_reg == ST_INIT || (upd_ctr && shared_table_reg);
    assign sh_waddr  = state_reg == ST_INIT ? sweep_reg : cidx_reg;
    assign sh_wdata  = state_reg == ST_INIT ? CTR_RESET : ctr_new_c;

    // ---------------- sequencer ----------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_INIT:  if (sweep_reg == 8'hff) state_next = ST_IDLE;
            ST_IDLE:  if (s_fire) state_next = ST_ENTRY;
            ST_ENTRY: state_next = alloc_c ? ST_SWEEP : ST_CTR;
            ST_SWEEP: if (sweep_reg == 8'hff) state_next = ST_CTR;
            ST_CTR:   state_next = ST_OUT;
            ST_OUT:   if (!m_valid_reg) state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    logic flush_c;
    assign flush_c = (tk_reg && tgt_reg != pred_reg) ||
                     (!tk_reg && pred_reg != pc_reg + 32'd4);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_INIT;
            sweep_reg   <= 8'd0;
            valid_reg   <= '0;
            ghist_reg   <= 8'd0;
            branch_reg  <= 32'd0;
            flush_reg   <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (state_reg == ST_INIT || state_reg == ST_SWEEP) begin
                // advance the sweep pointer, wrap to zero at the end
                sweep_reg <= sweep_reg + 8'd1;
            end
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            if (state_reg == ST_CTR) begin
                m_valid_reg <= 1'b1;
                if (op_reg == OP_UPDATE) begin
                    valid_reg[slot_reg] <= 1'b1;
                    branch_reg <= branch_reg + 32'd1;
                    if (flush_c) flush_reg <= flush_reg + 32'd1;
                    if (shared_history_reg)
                        ghist_reg <= {ghist_reg[6:0], tk_reg} & hmask;
                end
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            op_reg   <= s_operation;
            pc_reg   <= s_pc;
            tgt_reg  <= s_actual_target;
            tk_reg   <= s_taken;
            pred_reg <= s_predicted_target;
            slot_reg <= in_slot;
            tag_reg  <= in_tag;
        end
        if (state_reg == ST_ENTRY) begin
            hit_reg     <= hit_c;
            etarget_reg <= ent_rdata[31:0];
            if (alloc_c) lhist_reg[slot_reg] <= 8'd0;
        end
        if (state_reg == ST_ENTRY || state_reg == ST_SWEEP) begin
            cidx_reg <= cidx_next_c;
            hist_reg <= hist_c;
        end
        if (upd_ctr && !shared_history_reg)
            lhist_reg[slot_reg] <= {hist_reg[6:0], tk_reg} & hmask;
        if (state_reg == ST_CTR) begin
            if (op_reg == OP_PREDICT && hit_reg && ctr_c[1]) begin
                ptaken_reg <= 1'b1;
                npc_reg    <= etarget_reg;
            end else begin
                ptaken_reg <= 1'b0;
                npc_reg    <= op_reg == OP_PREDICT ? pc_reg + 32'd4 : 32'd0;
            end
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_predict_taken = ptaken_reg;
    assign m_next_pc       = npc_reg;
    assign m_branch_count  = branch_reg;
    assign m_flush_count   = flush_reg;
endmodule

>>> sv/btb_checker.sv
// ----------------------------------------------------------------------------
// BTB predictor checker
// Port-level properties of the predictor, bound to the top level.
// ----------------------------------------------------------------------------
module btb_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic        m_predict_taken,
    input logic [31:0] m_next_pc,
    input logic [31:0] m_branch_count
);
    // hold the result until the transfer
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_next_pc))
        else $error("result dropped");
    // one item at a time: no input while a result waits
    a_one: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !s_ready)
        else $error("input taken while result pending");
    // drop ready right after an input transfer
    a_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready && !m_valid)
        else $error("input accepted while busy");
    // an update reports no prediction
    a_upd: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_branch_count != $past(m_branch_count) |-> !m_predict_taken)
        else $error("update reported taken");
    // clear the result valid on reset
    a_rst: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("valid after reset");
endmodule

bind btb_two_level_branch_predictor btb_checker u_btb_checker (
    .aclk(aclk), .aresetn(aresetn), .s_valid(s_valid), .s_ready(s_ready),
    .m_valid(m_valid), .m_ready(m_ready),
    .m_predict_taken(m_predict_taken), .m_next_pc(m_next_pc),
    .m_branch_count(m_branch_count)
);
